// ----- rtl/ecwi_pkg.sv -----
// ----------------------------------------------------------------------------
// ecwi_pkg
// shared types, codes and constants of the edge counter with interrupt
// ----------------------------------------------------------------------------
package ecwi_pkg;

   // default widths of the counter and the time base
   localparam int COUNT_BITS_DEF = 32;
   localparam int TIME_BITS_DEF  = 32;

   // fixed widths of the transaction fields
   localparam int DATA_BITS      = 32;
   localparam int REQ_TDATA_BITS = 72;
   localparam int RSP_TDATA_BITS = 40;

   // reset value of the stored debounce time in ms
   localparam logic [7:0] DEBOUNCE_RESET = 8'd10;

   // operation codes
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_READ     = 2'd1;
   localparam logic [1:0] OP_WRITE    = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   // register indexes
   localparam logic [2:0] REG_VALUE  = 3'd0;
   localparam logic [2:0] REG_COUNT  = 3'd1;
   localparam logic [2:0] REG_EVERY  = 3'd2;
   localparam logic [2:0] REG_PERIOD = 3'd3;
   localparam logic [2:0] REG_MODE   = 3'd4;

   // result kinds
   localparam logic [2:0] KIND_READ   = 3'd0;
   localparam logic [2:0] KIND_ACK    = 3'd1;
   localparam logic [2:0] KIND_UNSUPP = 3'd2;
   localparam logic [2:0] KIND_EVENT  = 3'd3;
   localparam logic [2:0] KIND_REPORT = 3'd4;

   // edge modes
   localparam logic [1:0] MODE_RISING  = 2'd0;
   localparam logic [1:0] MODE_FALLING = 2'd1;
   localparam logic [1:0] MODE_BOTH    = 2'd2;
   localparam logic [1:0] MODE_NONE    = 2'd3;

   // one request transaction, unpacked
   typedef struct packed {
      logic [1:0]           operation;
      logic [2:0]           reg_index;
      logic [DATA_BITS-1:0] write_data;
      logic                 sample;
      logic [31:0]          time_ms;
   } req_item_type;

   // one response transaction, unpacked
   typedef struct packed {
      logic [2:0]           kind;
      logic [DATA_BITS-1:0] data;
      logic                 level;
   } rsp_item_type;

endpackage

// ----- rtl/edge_counter_with_interrupt_top.sv -----
// ----------------------------------------------------------------------------
// edge_counter_with_interrupt_top
// magnetic switch edge counter with edge events and periodic count reports
// ----------------------------------------------------------------------------
// The req channel carries ticks (sensor sample plus time in ms), register
// reads and register writes, selected by req_tuser. Each transaction yields
// at most one rsp transaction: read data, a write ack, an unsupported answer,
// an edge event or a periodic count report, its kind in rsp_tuser. A tick
// with no edge event and no due report yields nothing.
// A request is taken into the input register, processed by the core once
// the output register is free or draining, and its result lands in the
// output register. One request is taken every cycle while the receiver does
// not stall; the only loop is the state update in the core.
// When the receiver stalls, the held result stays on rsp and the held
// request waits in the input register; req_tready is low while both are full
// and rsp_tready is low, and rises in the cycle that rsp_tready frees the
// output register.
// Reset clears both registers, the counter, the level, the event and report
// bases, turns events and reports off, selects rising edges and sets the
// stored debounce time to ten ms. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module edge_counter_with_interrupt_top #(
   parameter int COUNT_BITS = ecwi_pkg::COUNT_BITS_DEF,
   parameter int TIME_BITS  = ecwi_pkg::TIME_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // reg_index[2:0], write_data[34:3], sample[35], time_ms[67:36], zero fill
   input  logic [ecwi_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // operation[1:0]
   input  logic [1:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // data[31:0], level[32], zero fill
   output logic [ecwi_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   // kind[2:0]
   output logic [2:0]                            rsp_tuser
);

   logic                   item_valid;
   logic                   advance;
   logic                   has_result;
   ecwi_pkg::req_item_type item;
   ecwi_pkg::rsp_item_type result;

   // process the held request when the output register can take its result
   assign advance = item_valid && (!rsp_tvalid || rsp_tready);

   // input register
   ecwi_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // state and decision logic
   ecwi_core #(
      .COUNT_BITS (COUNT_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (item),
      .has_result (has_result),
      .result     (result)
   );

   // output register
   ecwi_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .has_result (has_result),
      .result     (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- rtl/ecwi_in_stage.sv -----
// ----------------------------------------------------------------------------
// ecwi_in_stage
// request input register, unpacks the stream payload into one item
// ----------------------------------------------------------------------------
module ecwi_in_stage (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [ecwi_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   input  logic [1:0]                            req_tuser,
   input  logic                                  advance,
   output logic                                  item_valid,
   output ecwi_pkg::req_item_type                item
);

   logic                   valid_ff;
   logic                   valid_in;
   ecwi_pkg::req_item_type item_ff;
   ecwi_pkg::req_item_type item_in;

   // free when empty or when the held item moves on this cycle
   assign req_tready = !valid_ff || advance;

   // unpack the payload
   always_comb begin
      item_in.operation  = req_tuser;
      item_in.reg_index  = req_tdata[2:0];
      item_in.write_data = req_tdata[34:3];
      item_in.sample     = req_tdata[35];
      item_in.time_ms    = req_tdata[67:36];
   end

   // occupancy
   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- rtl/ecwi_core.sv -----
// ----------------------------------------------------------------------------
// ecwi_core
// register file, edge counter, event/report decision; one item a cycle on step
// ----------------------------------------------------------------------------
module ecwi_core #(
   parameter int COUNT_BITS = ecwi_pkg::COUNT_BITS_DEF,
   parameter int TIME_BITS  = ecwi_pkg::TIME_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  ecwi_pkg::req_item_type item,
   output logic                   has_result,
   output ecwi_pkg::rsp_item_type result
);

   localparam int DW = ecwi_pkg::DATA_BITS;
   localparam int TW = (TIME_BITS > DW) ? TIME_BITS : DW;

   logic                  level_ff;
   logic                  level_in;
   logic [COUNT_BITS-1:0] edge_count_ff;
   logic [COUNT_BITS-1:0] edge_count_in;
   logic [COUNT_BITS-1:0] last_evt_ff;
   logic [COUNT_BITS-1:0] last_evt_in;
   logic [TIME_BITS-1:0]  last_rep_ff;
   logic [TIME_BITS-1:0]  last_rep_in;
   logic [DW-1:0]         event_every_ff;
   logic [DW-1:0]         event_every_in;
   logic [DW-1:0]         report_period_ff;
   logic [DW-1:0]         report_period_in;
   logic [1:0]            edge_mode_ff;
   logic [1:0]            edge_mode_in;
   logic [7:0]            debounce_ff;
   logic [7:0]            debounce_in;

   logic                  changed;
   logic                  hit;
   logic [COUNT_BITS-1:0] count_tick;
   logic [COUNT_BITS-1:0] count_diff;
   logic                  evt_due;
   logic [TW-1:0]         time_wide;
   logic [TIME_BITS-1:0]  now;
   logic [TIME_BITS-1:0]  time_diff;
   logic                  rep_due;

   // edge detection and counting on a tick
   always_comb begin
      changed = item.sample != level_ff;
      unique case (edge_mode_ff)
         ecwi_pkg::MODE_RISING:  hit = item.sample;
         ecwi_pkg::MODE_FALLING: hit = !item.sample;
         ecwi_pkg::MODE_BOTH:    hit = 1'b1;
         ecwi_pkg::MODE_NONE:    hit = 1'b0;
      endcase
      count_tick = edge_count_ff + COUNT_BITS'(hit && changed);
      count_diff = count_tick - last_evt_ff;
      evt_due    = changed && (event_every_ff != '0) &&
                   (DW'(count_diff) >= event_every_ff);
   end

   // elapsed time since the last event or report
   always_comb begin
      time_wide = TW'(item.time_ms);
      now       = time_wide[TIME_BITS-1:0];
      time_diff = now - last_rep_ff;
      rep_due   = (report_period_ff != '0) &&
                  (TW'(time_diff) >= TW'(report_period_ff));
   end

   // next state and result
   always_comb begin
      level_in         = level_ff;
      edge_count_in    = edge_count_ff;
      last_evt_in      = last_evt_ff;
      last_rep_in      = last_rep_ff;
      event_every_in   = event_every_ff;
      report_period_in = report_period_ff;
      edge_mode_in     = edge_mode_ff;
      debounce_in      = debounce_ff;
      has_result       = 1'b0;
      result           = '0;
      if (step) begin
         unique case (item.operation)
            ecwi_pkg::OP_TICK: begin
               level_in      = item.sample;
               edge_count_in = count_tick;
               if (evt_due) begin
                  last_evt_in  = count_tick;
                  last_rep_in  = now;
                  has_result   = 1'b1;
                  result.kind  = ecwi_pkg::KIND_EVENT;
                  result.data  = DW'(count_tick);
                  result.level = item.sample;
               end else if (rep_due) begin
                  last_rep_in  = now;
                  has_result   = 1'b1;
                  result.kind  = ecwi_pkg::KIND_REPORT;
                  result.data  = DW'(count_tick);
                  result.level = item.sample;
               end
            end
            ecwi_pkg::OP_READ: begin
               has_result  = 1'b1;
               result.kind = ecwi_pkg::KIND_READ;
               unique case (item.reg_index)
                  ecwi_pkg::REG_VALUE:  result.data = DW'(level_ff);
                  ecwi_pkg::REG_COUNT:  result.data = DW'(edge_count_ff);
                  ecwi_pkg::REG_EVERY:  result.data = event_every_ff;
                  ecwi_pkg::REG_PERIOD: result.data = report_period_ff;
                  ecwi_pkg::REG_MODE:
                     result.data = {16'd0, debounce_ff, 6'd0, edge_mode_ff};
                  default:              result.kind = ecwi_pkg::KIND_UNSUPP;
               endcase
            end
            ecwi_pkg::OP_WRITE: begin
               has_result  = 1'b1;
               result.kind = ecwi_pkg::KIND_ACK;
               unique case (item.reg_index)
                  ecwi_pkg::REG_EVERY: begin
                     event_every_in = item.write_data;
                     last_evt_in    = edge_count_ff;
                  end
                  ecwi_pkg::REG_PERIOD: begin
                     report_period_in = item.write_data;
                  end
                  ecwi_pkg::REG_MODE: begin
                     edge_count_in = '0;
                     last_evt_in   = '0;
                     edge_mode_in  = item.write_data[1:0];
                     debounce_in   = item.write_data[15:8];
                  end
                  default: begin
                     result.kind = ecwi_pkg::KIND_UNSUPP;
                  end
               endcase
            end
            ecwi_pkg::OP_RESERVED: begin
               has_result  = 1'b1;
               result.kind = ecwi_pkg::KIND_UNSUPP;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff         <= 1'b0;
         edge_count_ff    <= '0;
         last_evt_ff      <= '0;
         last_rep_ff      <= '0;
         event_every_ff   <= '0;
         report_period_ff <= '0;
         edge_mode_ff     <= ecwi_pkg::MODE_RISING;
         debounce_ff      <= ecwi_pkg::DEBOUNCE_RESET;
      end else begin
         level_ff         <= level_in;
         edge_count_ff    <= edge_count_in;
         last_evt_ff      <= last_evt_in;
         last_rep_ff      <= last_rep_in;
         event_every_ff   <= event_every_in;
         report_period_ff <= report_period_in;
         edge_mode_ff     <= edge_mode_in;
         debounce_ff      <= debounce_in;
      end
   end

   // mode write clears the counter
   a_mode_clears: assert property (@(posedge clock) disable iff (reset)
      (step && item.operation == ecwi_pkg::OP_WRITE &&
       item.reg_index == ecwi_pkg::REG_MODE) |=> (edge_count_ff == '0))
      else $error("edge count not cleared by mode write");

   // events only fire when enabled
   a_event_enabled: assert property (@(posedge clock) disable iff (reset)
      (has_result && result.kind == ecwi_pkg::KIND_EVENT) |->
      (event_every_ff != '0))
      else $error("edge event with events off");

   // an event rebases the event counter
   a_event_rebase: assert property (@(posedge clock) disable iff (reset)
      (has_result && result.kind == ecwi_pkg::KIND_EVENT) |=>
      (last_evt_ff == edge_count_ff))
      else $error("event base not updated");

   // a tick advances the count by at most one
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      (step && item.operation == ecwi_pkg::OP_TICK) |=>
      (edge_count_ff == $past(edge_count_ff) ||
       edge_count_ff == COUNT_BITS'($past(edge_count_ff) + 1'b1)))
      else $error("edge count jumped on a tick");

   // state holds while no item is processed
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> ($stable(edge_count_ff) && $stable(level_ff)))
      else $error("state changed without an item");

endmodule

// ----- rtl/ecwi_out_stage.sv -----
// ----------------------------------------------------------------------------
// ecwi_out_stage
// response register, packs one result into the stream payload
// ----------------------------------------------------------------------------
module ecwi_out_stage (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  logic                                  has_result,
   input  ecwi_pkg::rsp_item_type                result,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [ecwi_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   output logic [2:0]                            rsp_tuser
);

   logic                   valid_ff;
   logic                   valid_in;
   ecwi_pkg::rsp_item_type item_ff;

   // a step only happens when this register is free or draining
   always_comb begin
      valid_in = valid_ff;
      if (step) begin
         valid_in = has_result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (step && has_result) begin
         item_ff <= result;
      end
   end

   // pack the payload
   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = item_ff.kind;
   assign rsp_tdata  = {7'd0, item_ff.level, item_ff.data};

endmodule
